// ----- rtl/core/cfd_pkg.sv -----
`timescale 1ns / 1ps

package cfd_pkg;

   // Field widths of the request and response.
   localparam int ID_W   = 29;
   localparam int DEST_W = 8;
   localparam int SLOT_W = 3;
   localparam int BUS_FW = 2;

   // Defaults of the top-level parameters.
   localparam int DEFAULT_BUSES = 2;
   localparam int DEFAULT_SLOTS = 8;

   // Operation and response kind codes.
   localparam logic OP_SUBSCRIBE = 1'b0;
   localparam logic OP_FRAME     = 1'b1;
   localparam logic KIND_ACK     = 1'b0;
   localparam logic KIND_DELIVER = 1'b1;

   // Request token that walks the row of slot cells, one cell per cycle.
   // The pending fields hold the latest claim or match; a pending match is
   // emitted once a later match proves it is not the last one.
   typedef struct packed {
      logic              valid;
      logic              op;
      logic [BUS_FW-1:0] bus;
      logic [ID_W-1:0]   id;
      logic [ID_W-1:0]   mask;
      logic              ext;
      logic [DEST_W-1:0] dest;
      logic              done;
      logic              pend_valid;
      logic [SLOT_W-1:0] pend_slot;
      logic [DEST_W-1:0] pend_dest;
   } token_type;

   // One response as produced by a cell or by the end of the row.
   typedef struct packed {
      logic              strobe;
      logic              kind;
      logic              accepted;
      logic [SLOT_W-1:0] slot;
      logic [DEST_W-1:0] dest;
      logic [ID_W-1:0]   frame_id;
      logic              last;
   } emit_type;

endpackage

// ----- rtl/core/can_subscriber_filter_dispatch.sv -----
`timescale 1ns / 1ps

// Channel   Handshake                 Payload
// request   start & !busy             req_operation .. req_frame_extended
// response  rsp_strobe (one cycle)    rsp_kind .. rsp_last
//
// Each request passes through the request register, each slot cell of the row
// in turn, and the response register. Busy is high from the accepted start
// until the cycle that shows the final response.
// A subscribe gives one acknowledgement; a frame gives up to SLOTS deliveries,
// at most one per cycle, in slot order, the final one marked last.
// Synchronous reset clears the used flags, so all tables start empty.
// The receiver cannot stall; responses are shown for one cycle only.

module can_subscriber_filter_dispatch #(
   parameter int BUSES = cfd_pkg::DEFAULT_BUSES,
   parameter int SLOTS = cfd_pkg::DEFAULT_SLOTS
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic                        req_operation,
   input  logic [cfd_pkg::BUS_FW-1:0]  req_bus,
   input  logic [cfd_pkg::ID_W-1:0]    req_filter_id,
   input  logic [cfd_pkg::ID_W-1:0]    req_filter_mask,
   input  logic                        req_want_extended,
   input  logic [cfd_pkg::DEST_W-1:0]  req_dest_tag,
   input  logic [cfd_pkg::ID_W-1:0]    req_frame_id,
   input  logic                        req_frame_extended,
   output logic                        rsp_strobe,
   output logic                        rsp_kind,
   output logic                        rsp_accepted,
   output logic [cfd_pkg::SLOT_W-1:0]  rsp_slot,
   output logic [cfd_pkg::DEST_W-1:0]  rsp_out_dest,
   output logic [cfd_pkg::ID_W-1:0]    rsp_out_frame_id,
   output logic                        rsp_last
);

   cfd_pkg::token_type tok [0:SLOTS];
   cfd_pkg::emit_type  cell_emit [0:SLOTS-1];
   logic [SLOTS-1:0]   emit_strobes;

   cfd_pkg::token_type req_ff;
   cfd_pkg::token_type req_in;
   cfd_pkg::emit_type  rsp_ff;
   cfd_pkg::emit_type  rsp_in;
   cfd_pkg::emit_type  tail_emit;
   logic               busy_ff;
   logic               busy_in;
   logic               take;

   assign take = start && !busy_ff;

   // Request register at the head of the row.
   always_comb begin
      req_in            = '0;
      req_in.valid      = take;
      req_in.op         = req_operation;
      req_in.bus        = req_bus;
      if (req_operation == cfd_pkg::OP_SUBSCRIBE) begin
         req_in.id      = req_filter_id;
         req_in.mask    = req_filter_mask;
         req_in.ext     = req_want_extended;
         req_in.dest    = req_dest_tag;
      end else begin
         req_in.id      = req_frame_id;
         req_in.ext     = req_frame_extended;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_ff.valid <= 1'b0;
      end else begin
         req_ff <= req_in;
      end
   end

   assign tok[0] = req_ff;

   // Row of slot cells.
   for (genvar i = 0; i < SLOTS; i++) begin : g_cell
      cfd_slot_cell #(
         .BUSES      (BUSES),
         .SLOT_INDEX (i)
      ) u_cell (
         .clock  (clock),
         .reset  (reset),
         .tok_i  (tok[i]),
         .tok_o  (tok[i+1]),
         .emit_o (cell_emit[i])
      );
      assign emit_strobes[i] = cell_emit[i].strobe;
   end

   // End of the row: acknowledgement or the final delivery.
   always_comb begin
      tail_emit = '0;
      if (tok[SLOTS].valid) begin
         tail_emit.last = 1'b1;
         if (tok[SLOTS].op == cfd_pkg::OP_SUBSCRIBE) begin
            tail_emit.strobe   = 1'b1;
            tail_emit.kind     = cfd_pkg::KIND_ACK;
            tail_emit.accepted = tok[SLOTS].done;
            if (tok[SLOTS].done) begin
               tail_emit.slot = tok[SLOTS].pend_slot;
               tail_emit.dest = tok[SLOTS].pend_dest;
            end
         end else if (tok[SLOTS].pend_valid) begin
            tail_emit.strobe   = 1'b1;
            tail_emit.kind     = cfd_pkg::KIND_DELIVER;
            tail_emit.slot     = tok[SLOTS].pend_slot;
            tail_emit.dest     = tok[SLOTS].pend_dest;
            tail_emit.frame_id = tok[SLOTS].id;
         end
      end
   end

   // Only the cell holding the token can emit, so the responses merge by OR.
   always_comb begin
      rsp_in = tail_emit;
      for (int i = 0; i < SLOTS; i++) begin
         rsp_in = rsp_in | cell_emit[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_ff.strobe <= 1'b0;
      end else begin
         rsp_ff <= rsp_in;
      end
   end

   // Busy covers the whole walk of the token.
   always_comb begin
      busy_in = busy_ff;
      if (take) begin
         busy_in = 1'b1;
      end else if (tok[SLOTS].valid) begin
         busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   assign busy             = busy_ff;
   assign rsp_strobe       = rsp_ff.strobe;
   assign rsp_kind         = rsp_ff.kind;
   assign rsp_accepted     = rsp_ff.accepted;
   assign rsp_slot         = rsp_ff.slot;
   assign rsp_out_dest     = rsp_ff.dest;
   assign rsp_out_frame_id = rsp_ff.frame_id;
   assign rsp_last         = rsp_ff.last;

`ifndef SYNTHESIS
   // At most one cell releases a delivery in any cycle.
   a_one_emit: assert property (@(posedge clock) disable iff (reset)
      $onehot0(emit_strobes))
      else $error("more than one slot cell emitted in one cycle");

   // An accepted request holds busy on the next cycle.
   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      take |=> busy)
      else $error("busy not raised after an accepted request");

   // The final response of a request coincides with busy falling.
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_last) |-> !busy)
      else $error("busy still high with the final response");

   // An acknowledgement is always the only and last response.
   a_ack_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_kind == cfd_pkg::KIND_ACK)) |-> rsp_last)
      else $error("acknowledgement not marked last");

   // Responses only come out of a request in progress.
   a_rsp_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy))
      else $error("response without a request in progress");
`endif

endmodule

// ----- rtl/core/cfd_slot_cell.sv -----
`timescale 1ns / 1ps

module cfd_slot_cell #(
   parameter int BUSES      = cfd_pkg::DEFAULT_BUSES,
   parameter int SLOT_INDEX = 0
) (
   input  logic               clock,
   input  logic               reset,
   input  cfd_pkg::token_type tok_i,
   output cfd_pkg::token_type tok_o,
   output cfd_pkg::emit_type  emit_o
);

   localparam int BUS_W = (BUSES > 1) ? $clog2(BUSES) : 1;
   localparam logic [cfd_pkg::SLOT_W-1:0] MY_SLOT = cfd_pkg::SLOT_W'(SLOT_INDEX);

   // This slot's subscriber entry for every bus.
   logic                        used_ff [0:BUSES-1];
   logic [cfd_pkg::ID_W-1:0]    id_ff   [0:BUSES-1];
   logic [cfd_pkg::ID_W-1:0]    mask_ff [0:BUSES-1];
   logic                        ext_ff  [0:BUSES-1];
   logic [cfd_pkg::DEST_W-1:0]  dest_ff [0:BUSES-1];

   cfd_pkg::token_type tok_ff;
   cfd_pkg::token_type tok_in;

   logic [BUS_W-1:0] bidx;
   logic             in_range;
   logic             claim;
   logic             match;

   assign bidx     = tok_i.bus[BUS_W-1:0];
   assign in_range = int'(tok_i.bus) < BUSES;

   // A subscribe with a nonzero destination on a bus in range claims this slot when no earlier cell did and it is free.
   assign claim = tok_i.valid && (tok_i.op == cfd_pkg::OP_SUBSCRIBE) && !tok_i.done
                  && in_range && (tok_i.dest != '0) && !used_ff[bidx];

   // A frame matches on equal format and equal identifier bits under the mask.
   assign match = tok_i.valid && (tok_i.op == cfd_pkg::OP_FRAME) && in_range
                  && used_ff[bidx] && (ext_ff[bidx] == tok_i.ext)
                  && (((tok_i.id ^ id_ff[bidx]) & mask_ff[bidx]) == '0);

   // Update the token and release an earlier match that is now known not last.
   always_comb begin
      tok_in = tok_i;
      emit_o = '0;
      if (claim) begin
         tok_in.done      = 1'b1;
         tok_in.pend_slot = MY_SLOT;
         tok_in.pend_dest = tok_i.dest;
      end
      if (match) begin
         tok_in.pend_valid = 1'b1;
         tok_in.pend_slot  = MY_SLOT;
         tok_in.pend_dest  = dest_ff[bidx];
         if (tok_i.pend_valid) begin
            emit_o.strobe   = 1'b1;
            emit_o.kind     = cfd_pkg::KIND_DELIVER;
            emit_o.slot     = tok_i.pend_slot;
            emit_o.dest     = tok_i.pend_dest;
            emit_o.frame_id = tok_i.id;
         end
      end
   end

   // Hand the token to the next cell.
   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff.valid <= 1'b0;
      end else begin
         tok_ff <= tok_in;
      end
   end

   assign tok_o = tok_ff;

   // Entry storage; only the used flags need a reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int b = 0; b < BUSES; b++) begin
            used_ff[b] <= 1'b0;
         end
      end else if (claim) begin
         used_ff[bidx] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (claim) begin
         id_ff[bidx]   <= tok_i.id;
         mask_ff[bidx] <= tok_i.mask;
         ext_ff[bidx]  <= tok_i.ext;
         dest_ff[bidx] <= tok_i.dest;
      end
   end

endmodule

// ----- tb/sv/can_subscriber_filter_dispatch_tb.sv -----
`timescale 1ns / 1ps

module can_subscriber_filter_dispatch_tb;

   localparam int BUSES = cfd_pkg::DEFAULT_BUSES;
   localparam int SLOTS = cfd_pkg::DEFAULT_SLOTS;
   localparam logic [cfd_pkg::ID_W-1:0] ID_ALL = '1;
   localparam int RANDOM_ITEMS = 320;
   localparam int QUIET_FIRST = 120;
   localparam int QUIET_LAST = 200;
   localparam int CYCLE_LIMIT = 200000;

   // One request as the sender presents it.
   typedef struct packed {
      logic                       operation;
      logic [cfd_pkg::BUS_FW-1:0] bus;
      logic [cfd_pkg::ID_W-1:0]   filter_id;
      logic [cfd_pkg::ID_W-1:0]   filter_mask;
      logic                       want_ext;
      logic [cfd_pkg::DEST_W-1:0] dest_tag;
      logic [cfd_pkg::ID_W-1:0]   frame_id;
      logic                       frame_ext;
   } can_req_type;

   // One acknowledgement or delivery.
   typedef struct packed {
      logic                       kind;
      logic                       accepted;
      logic [cfd_pkg::SLOT_W-1:0] slot;
      logic [cfd_pkg::DEST_W-1:0] dest;
      logic [cfd_pkg::ID_W-1:0]   frame_id;
      logic                       last;
   } filter_rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   can_req_type cur_req = '0;
   logic rsp_strobe;
   logic rsp_kind;
   logic rsp_accepted;
   logic [cfd_pkg::SLOT_W-1:0] rsp_slot;
   logic [cfd_pkg::DEST_W-1:0] rsp_out_dest;
   logic [cfd_pkg::ID_W-1:0] rsp_out_frame_id;
   logic rsp_last;

   // Requests waiting to be sent and responses still due.
   can_req_type req_backlog_q[$];
   filter_rsp_type due_rsp_q[$];
   int fail_count = 0;
   int sent_count = 0;
   int cycle_count = 0;

   // Predicted subscriber tables.
   bit tbl_used[BUSES][SLOTS];
   logic [cfd_pkg::ID_W-1:0] tbl_id[BUSES][SLOTS];
   logic [cfd_pkg::ID_W-1:0] tbl_mask[BUSES][SLOTS];
   bit tbl_ext[BUSES][SLOTS];
   logic [cfd_pkg::DEST_W-1:0] tbl_dest[BUSES][SLOTS];

   // Subscriptions known at generation time, used to build matching frames.
   int gen_count[BUSES];
   logic [cfd_pkg::ID_W-1:0] gen_id[BUSES][SLOTS];
   logic [cfd_pkg::ID_W-1:0] gen_mask[BUSES][SLOTS];
   bit gen_ext[BUSES][SLOTS];

   can_subscriber_filter_dispatch #(
      .BUSES(BUSES),
      .SLOTS(SLOTS)
   ) uut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_operation(cur_req.operation),
      .req_bus(cur_req.bus),
      .req_filter_id(cur_req.filter_id),
      .req_filter_mask(cur_req.filter_mask),
      .req_want_extended(cur_req.want_ext),
      .req_dest_tag(cur_req.dest_tag),
      .req_frame_id(cur_req.frame_id),
      .req_frame_extended(cur_req.frame_ext),
      .rsp_strobe(rsp_strobe),
      .rsp_kind(rsp_kind),
      .rsp_accepted(rsp_accepted),
      .rsp_slot(rsp_slot),
      .rsp_out_dest(rsp_out_dest),
      .rsp_out_frame_id(rsp_out_frame_id),
      .rsp_last(rsp_last)
   );

   // Clock with a 10 ns period.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Queue a subscribe request; the frame fields carry random filler.
   task automatic queue_subscribe(input int b, input logic [cfd_pkg::ID_W-1:0] id,
                                  input logic [cfd_pkg::ID_W-1:0] mask, input bit ext,
                                  input logic [cfd_pkg::DEST_W-1:0] tag);
      can_req_type r;
      r.operation = cfd_pkg::OP_SUBSCRIBE;
      r.bus = cfd_pkg::BUS_FW'(b);
      r.filter_id = id;
      r.filter_mask = mask;
      r.want_ext = ext;
      r.dest_tag = tag;
      r.frame_id = cfd_pkg::ID_W'($urandom);
      r.frame_ext = 1'($urandom_range(1));
      req_backlog_q.push_back(r);
      if (b < BUSES && tag != 0 && gen_count[b] < SLOTS) begin
         gen_id[b][gen_count[b]] = id;
         gen_mask[b][gen_count[b]] = mask;
         gen_ext[b][gen_count[b]] = ext;
         gen_count[b]++;
      end
   endtask

   // Queue a frame request; the subscribe fields carry random filler.
   task automatic queue_frame(input int b, input logic [cfd_pkg::ID_W-1:0] id,
                              input bit ext);
      can_req_type r;
      r.operation = cfd_pkg::OP_FRAME;
      r.bus = cfd_pkg::BUS_FW'(b);
      r.filter_id = cfd_pkg::ID_W'($urandom);
      r.filter_mask = cfd_pkg::ID_W'($urandom);
      r.want_ext = 1'($urandom_range(1));
      r.dest_tag = cfd_pkg::DEST_W'($urandom);
      r.frame_id = id;
      r.frame_ext = ext;
      req_backlog_q.push_back(r);
   endtask

   // Work out the responses of one accepted request and update the tables.
   task automatic filter_and_dispatch(input can_req_type r);
      filter_rsp_type rsp;
      filter_rsp_type hits[$];
      int b;
      bit taken;
      b = r.bus;
      taken = 1'b0;
      if (r.operation == cfd_pkg::OP_SUBSCRIBE) begin
         rsp = '{cfd_pkg::KIND_ACK, 1'b0, '0, '0, '0, 1'b1};
         if (b < BUSES && r.dest_tag != 0) begin
            for (int s = 0; s < SLOTS; s++) begin
               if (!taken && !tbl_used[b][s]) begin
                  taken = 1'b1;
                  tbl_used[b][s] = 1'b1;
                  tbl_id[b][s] = r.filter_id;
                  tbl_mask[b][s] = r.filter_mask;
                  tbl_ext[b][s] = r.want_ext;
                  tbl_dest[b][s] = r.dest_tag;
                  rsp.accepted = 1'b1;
                  rsp.slot = cfd_pkg::SLOT_W'(s);
                  rsp.dest = r.dest_tag;
               end
            end
         end
         due_rsp_q.push_back(rsp);
      end else if (b < BUSES) begin
         // Deliveries come out in ascending slot order.
         for (int s = 0; s < SLOTS; s++) begin
            if (tbl_used[b][s] && tbl_ext[b][s] == r.frame_ext &&
                ((r.frame_id ^ tbl_id[b][s]) & tbl_mask[b][s]) == '0) begin
               hits.push_back('{cfd_pkg::KIND_DELIVER, 1'b0, cfd_pkg::SLOT_W'(s),
                                tbl_dest[b][s], r.frame_id, 1'b0});
            end
         end
         if (hits.size() > 0) begin
            hits[hits.size() - 1].last = 1'b1;
         end
         foreach (hits[i]) begin
            due_rsp_q.push_back(hits[i]);
         end
      end
   endtask

   // Sender: holds each request until its transfer, idles at random between them outside [QUIET_FIRST, QUIET_LAST).
   always @(posedge clock) begin : sender
      logic launch;
      launch = start;
      if (reset) begin
         launch = 1'b0;
      end else begin
         if (start && !busy) begin
            filter_and_dispatch(cur_req);
            launch = 1'b0;
         end
         if (!launch && req_backlog_q.size() > 0 &&
             ((sent_count >= QUIET_FIRST && sent_count < QUIET_LAST) ||
              $urandom_range(99) >= 23)) begin
            cur_req <= req_backlog_q.pop_front();
            sent_count <= sent_count + 1;
            launch = 1'b1;
         end
      end
      start <= launch;
   end

   task automatic check_field(input string name, input longint unsigned want,
                              input longint unsigned got);
      if (want != got) begin
         $error("%s mismatch: expected %0h, actual %0h", name, want, got);
         fail_count++;
      end
   endtask

   // Receiver: every strobed response is compared with the oldest one due.
   always @(posedge clock) begin : receiver
      filter_rsp_type want;
      if (!reset && rsp_strobe) begin
         if (due_rsp_q.size() == 0) begin
            $error("Response with none due: kind %0h slot %0h dest %0h", rsp_kind,
                   rsp_slot, rsp_out_dest);
            fail_count++;
         end else begin
            want = due_rsp_q.pop_front();
            check_field("kind", want.kind, rsp_kind);
            check_field("accepted", want.accepted, rsp_accepted);
            check_field("slot", want.slot, rsp_slot);
            check_field("out_dest", want.dest, rsp_out_dest);
            check_field("out_frame_id", want.frame_id, rsp_out_frame_id);
            check_field("last", want.last, rsp_last);
         end
      end
   end

   // Watchdog on the length of the run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   initial begin : stimulus
      int b;
      int pick;
      logic [cfd_pkg::ID_W-1:0] mask;
      logic [cfd_pkg::ID_W-1:0] id;
      foreach (gen_count[i]) begin
         gen_count[i] = 0;
      end

      // Directed: empty table, each rejection, and a fully matching bus.
      queue_frame(0, 29'h0000_1234, 1'b0);
      queue_subscribe(0, cfd_pkg::ID_W'($urandom), cfd_pkg::ID_W'($urandom), 1'b0, 8'd0);
      queue_subscribe(2, cfd_pkg::ID_W'($urandom), cfd_pkg::ID_W'($urandom), 1'b1, 8'd17);
      queue_subscribe(3, ID_ALL, ID_ALL, 1'b1, 8'd255);
      queue_subscribe(0, ID_ALL, ID_ALL, 1'b1, 8'd255);
      queue_subscribe(0, '0, '0, 1'b0, 8'd1);
      for (int k = 0; k < SLOTS; k++) begin
         queue_subscribe(1, '0, ID_ALL >> k, 1'b0, cfd_pkg::DEST_W'(8'h80 + k));
      end
      queue_subscribe(1, ID_ALL, ID_ALL, 1'b1, 8'h7f);
      queue_frame(0, ID_ALL, 1'b1);
      queue_frame(0, 29'h00AB_CDEF, 1'b0);
      queue_frame(0, ID_ALL, 1'b0);
      queue_frame(1, '0, 1'b0);
      queue_frame(1, 29'h1000_0000, 1'b0);
      queue_frame(1, ID_ALL, 1'b0);
      queue_frame(1, 29'h1, 1'b0);
      queue_frame(2, '0, 1'b0);
      queue_frame(3, ID_ALL, 1'b1);

      // Random: mostly frames aimed at stored filters, some subscribes and noise.
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         pick = $urandom_range(99);
         if (pick < 15) begin
            case ($urandom_range(3))
               0: mask = '0;
               1: mask = ID_ALL;
               2: mask = cfd_pkg::ID_W'($urandom);
               default: mask = cfd_pkg::ID_W'($urandom & $urandom);
            endcase
            queue_subscribe($urandom_range(7) == 0 ? $urandom_range(3) : $urandom_range(1),
                            cfd_pkg::ID_W'($urandom), mask, 1'($urandom_range(1)),
                            $urandom_range(15) == 0 ? 8'd0 : 8'($urandom_range(255, 1)));
         end else if (pick < 80) begin
            b = $urandom_range(BUSES - 1);
            if (gen_count[b] == 0) begin
               queue_frame(b, cfd_pkg::ID_W'($urandom), 1'($urandom_range(1)));
            end else begin
               pick = $urandom_range(gen_count[b] - 1);
               id = (gen_id[b][pick] & gen_mask[b][pick]) |
                    (cfd_pkg::ID_W'($urandom) & ~gen_mask[b][pick]);
               queue_frame(b, id, gen_ext[b][pick]);
            end
         end else begin
            queue_frame($urandom_range(3), cfd_pkg::ID_W'($urandom),
                        1'($urandom_range(1)));
         end
      end

      // Reset, then wait for every request and response to drain.
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      while (req_backlog_q.size() != 0 || start) @(negedge clock);
      while (due_rsp_q.size() != 0) @(negedge clock);
      repeat (SLOTS + 4) @(negedge clock);
      if (fail_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
